// File: rtl/rrc_pkg.sv
package rrc_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int ADDR_BITS     = 48;
  localparam int SIZE_BITS     = 32;
  localparam int REDZONE_BYTES = 16;

  localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
  // Wide enough for an offset and for user size plus both red zones.
  localparam int LIM_BITS = ((ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS) + 1;

  localparam logic [ADDR_BITS-1:0] RZ_ADDR   = ADDR_BITS'(REDZONE_BYTES);
  localparam logic [SIZE_BITS-1:0] STACK_PAD = SIZE_BITS'(2 * REDZONE_BYTES);
  localparam logic [LIM_BITS-1:0]  RZ_LIM    = LIM_BITS'(REDZONE_BYTES);
  localparam logic [LIM_BITS-1:0]  RZ2_LIM   = LIM_BITS'(2 * REDZONE_BYTES);
  localparam logic [CNT_BITS-1:0]  DEPTH_CNT = CNT_BITS'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    CMD_HEAP  = 2'd0,
    CMD_STACK = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_CHECK = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_UNDERFLOW      = 3'd1,
    ST_OVERFLOW       = 3'd2,
    ST_USE_AFTER_FREE = 3'd3,
    ST_TABLE_FULL     = 3'd4,
    ST_BAD_SIZE       = 3'd5
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [ADDR_BITS-1:0] address;
    logic [SIZE_BITS-1:0] size;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [ADDR_BITS-1:0] user_address;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [SIZE_BITS-1:0] user_size;
    logic                 freed;
  } entry_t;

  // Status of the compare unit toward the sequencer.
  typedef struct packed {
    logic                pending;
    logic                hit;
    status_t             status;
    logic [IDX_BITS-1:0] idx;
  } cmp_status_t;

endpackage

// File: rtl/rrc_ram.sv
module rrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/rrc_cmp_unit.sv
module rrc_cmp_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          flush,
  input  logic                          issue,
  input  logic [rrc_pkg::IDX_BITS-1:0]  issue_idx,
  input  rrc_pkg::entry_t               rd_entry,
  input  logic [rrc_pkg::ADDR_BITS-1:0] addr,
  input  rrc_pkg::cmd_t                 cmd,
  output rrc_pkg::entry_t               stg_entry,
  output rrc_pkg::cmp_status_t          cs
);

  logic                          rd_valid_r;
  logic [rrc_pkg::IDX_BITS-1:0]  rd_idx_r;
  logic                          stg_valid_r;
  logic [rrc_pkg::IDX_BITS-1:0]  stg_idx_r;
  logic [rrc_pkg::ADDR_BITS-1:0] off_r;
  rrc_pkg::entry_t               stg_entry_r;

  logic [rrc_pkg::LIM_BITS-1:0] off_ext;
  logic [rrc_pkg::LIM_BITS-1:0] lim_user;
  logic [rrc_pkg::LIM_BITS-1:0] lim_right;
  logic                         under;
  logic                         in_user;
  logic                         in_right;

  // Stage one: RAM data arrives; stage two: offset from the region base.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      stg_valid_r <= 1'b0;
    end else if (flush) begin
      rd_valid_r  <= 1'b0;
      stg_valid_r <= 1'b0;
    end else begin
      rd_valid_r  <= issue;
      stg_valid_r <= rd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= issue_idx;
    stg_idx_r   <= rd_idx_r;
    off_r       <= addr - rd_entry.base;
    stg_entry_r <= rd_entry;
  end

  always_comb begin
    off_ext   = rrc_pkg::LIM_BITS'(off_r);
    lim_user  = rrc_pkg::LIM_BITS'(stg_entry_r.user_size) + rrc_pkg::RZ_LIM;
    lim_right = rrc_pkg::LIM_BITS'(stg_entry_r.user_size) + rrc_pkg::RZ2_LIM;
    under     = off_ext < rrc_pkg::RZ_LIM;
    in_user   = !under && (off_ext < lim_user);
    in_right  = !under && !in_user && (off_ext < lim_right);

    cs.pending = rd_valid_r || stg_valid_r;
    cs.idx     = stg_idx_r;
    cs.hit     = 1'b0;
    cs.status  = rrc_pkg::ST_OK;
    if (stg_valid_r) begin
      if (cmd == rrc_pkg::CMD_FREE) begin
        // A free matches when the pointer is exactly the user start.
        cs.hit = (off_r == rrc_pkg::RZ_ADDR);
      end else begin
        priority if (under) begin
          cs.hit    = 1'b1;
          cs.status = rrc_pkg::ST_UNDERFLOW;
        end else if (in_right) begin
          cs.hit    = 1'b1;
          cs.status = rrc_pkg::ST_OVERFLOW;
        end else if (in_user && stg_entry_r.freed) begin
          cs.hit    = 1'b1;
          cs.status = rrc_pkg::ST_USE_AFTER_FREE;
        end else begin
          cs.hit = 1'b0;
        end
      end
    end
  end

  assign stg_entry = stg_entry_r;

endmodule

// File: rtl/redzone_region_checker_core.sv
// Channel   Handshake                Payload
// input     start / busy             in_data  (cmd, address, size)
// result    out_valid (strobe)       out_data (status, user_address)
//
// Registrations do not scan the table: the result strobes in the cycle after start.
// Free and check scan the table newest first, one entry per cycle through the
// RAM read port and a two-stage compare unit, and end early at the first match.
// Synchronous active-low reset empties the table; no clearing pass is needed.
// The receiver cannot stall; each result is valid for exactly one cycle.
module redzone_region_checker_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rrc_pkg::in_item_t   in_data,
  output logic                out_valid,
  output rrc_pkg::out_item_t  out_data
);

  rrc_pkg::state_t               state_r, state_nxt;
  logic [rrc_pkg::CNT_BITS-1:0]  count_r, count_nxt;
  logic [rrc_pkg::CNT_BITS-1:0]  iss_r, iss_nxt;
  rrc_pkg::cmd_t                 cmd_r, cmd_nxt;
  logic [rrc_pkg::ADDR_BITS-1:0] addr_r, addr_nxt;
  logic                          out_valid_r, out_valid_nxt;
  rrc_pkg::out_item_t            out_data_r, out_data_nxt;

  logic                          we;
  logic [rrc_pkg::IDX_BITS-1:0]  waddr;
  rrc_pkg::entry_t               wdata;
  logic                          issue;
  logic [rrc_pkg::CNT_BITS-1:0]  iss_dec;
  logic [rrc_pkg::IDX_BITS-1:0]  issue_idx;
  rrc_pkg::entry_t               rd_entry;
  rrc_pkg::entry_t               stg_entry;
  rrc_pkg::cmp_status_t          cs;
  logic                          flush;
  logic                          full;

  rrc_ram #(
    .WIDTH ($bits(rrc_pkg::entry_t)),
    .DEPTH (rrc_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (issue_idx),
    .rdata (rd_entry)
  );

  rrc_cmp_unit u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (flush),
    .issue     (issue),
    .issue_idx (issue_idx),
    .rd_entry  (rd_entry),
    .addr      (addr_r),
    .cmd       (cmd_r),
    .stg_entry (stg_entry),
    .cs        (cs)
  );

  assign full      = (count_r == rrc_pkg::DEPTH_CNT);
  assign iss_dec   = iss_r - 1'b1;
  assign issue_idx = iss_dec[rrc_pkg::IDX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrc_pkg::S_IDLE;
      count_r     <= '0;
      iss_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      iss_r       <= iss_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    addr_r     <= addr_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    iss_nxt       = iss_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    waddr         = count_r[rrc_pkg::IDX_BITS-1:0];
    wdata         = '{base: in_data.address, user_size: in_data.size, freed: 1'b0};
    issue         = 1'b0;
    flush         = 1'b0;

    unique case (state_r)
      rrc_pkg::S_IDLE: begin
        if (start) begin
          out_data_nxt.status       = rrc_pkg::ST_OK;
          out_data_nxt.user_address = '0;
          cmd_nxt                   = in_data.cmd;
          addr_nxt                  = in_data.address;
          unique case (in_data.cmd)
            rrc_pkg::CMD_HEAP, rrc_pkg::CMD_STACK: begin
              out_valid_nxt = 1'b1;
              priority if (full) begin
                out_data_nxt.status = rrc_pkg::ST_TABLE_FULL;
              end else if (in_data.cmd == rrc_pkg::CMD_STACK &&
                           in_data.size < rrc_pkg::STACK_PAD) begin
                out_data_nxt.status = rrc_pkg::ST_BAD_SIZE;
              end else begin
                we = 1'b1;
                if (in_data.cmd == rrc_pkg::CMD_STACK) begin
                  wdata.user_size = in_data.size - rrc_pkg::STACK_PAD;
                end
                count_nxt                 = count_r + 1'b1;
                out_data_nxt.user_address = in_data.address + rrc_pkg::RZ_ADDR;
              end
            end
            rrc_pkg::CMD_FREE, rrc_pkg::CMD_CHECK: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                iss_nxt   = count_r;
                state_nxt = rrc_pkg::S_SCAN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      rrc_pkg::S_SCAN: begin
        issue = (iss_r != '0) && !cs.hit;
        if (issue) begin
          iss_nxt = iss_dec;
        end
        if (cs.hit) begin
          // The first matching region, newest first, ends the scan.
          flush               = 1'b1;
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = cs.status;
          state_nxt           = rrc_pkg::S_IDLE;
          iss_nxt             = '0;
          if (cmd_r == rrc_pkg::CMD_FREE) begin
            we    = 1'b1;
            waddr = cs.idx;
            wdata = '{base: stg_entry.base, user_size: stg_entry.user_size, freed: 1'b1};
          end
        end else if (iss_r == '0 && !cs.pending) begin
          out_valid_nxt = 1'b1;
          state_nxt     = rrc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rrc_pkg::S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != rrc_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rrc_pkg::DEPTH_CNT)
    else $error("region count beyond table depth");

  a_heap_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.cmd == rrc_pkg::CMD_HEAP && !full)
    |=> (count_r == $past(count_r) + 1'b1) && out_valid)
    else $error("heap registration did not add a region");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == rrc_pkg::ST_TABLE_FULL)
    |-> count_r == rrc_pkg::DEPTH_CNT)
    else $error("table full reported with free entries");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rrc_pkg::S_IDLE) |-> !cs.pending)
    else $error("compare pipeline still holds entries while idle");

endmodule
